FILE: hw/rtl/lzss_pkg.sv
// Shared types and constants for the LZSS ring decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package lzss_pkg;

  localparam int WINDOW_BITS_DEF = 12;
  localparam int OUT_LANES_DEF   = 8;

  localparam int TOKEN_POS_W = 12;
  localparam int TOKEN_LEN_W = 4;
  localparam int LEN_W       = 9;
  localparam int CNT_W       = 4;
  localparam int POS_OUT_W   = 12;

  localparam logic [TOKEN_LEN_W-1:0] LEN_CODE_EXT = 4'hF;
  localparam logic [LEN_W-1:0]       LEN_BASE     = 9'd3;
  localparam logic [LEN_W-1:0]       LEN_EXT_BASE = 9'd18;

  typedef enum logic [1:0] {
    CTL_CLEAR,
    CTL_PARSE,
    CTL_COPY
  } ctl_state_t;

  typedef enum logic [2:0] {
    PH_FLAG,
    PH_LIT,
    PH_LO,
    PH_HI,
    PH_EXTRA
  } phase_t;

endpackage
`default_nettype wire

FILE: hw/rtl/lzss_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read-first on a same-address write. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module lzss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

FILE: hw/rtl/lzss_ring_decoder.sv
// Top level of the LZSS ring decoder: parser, match copy engine, output register.
// Depends on lzss_pkg and lzss_ram.
`timescale 1ns / 1ps
`default_nettype none
// After reset the ring is zeroed by a pass over all 2**WINDOW_BITS addresses
// (4096 by default) during which s_tready stays low; initial_position writes are
// taken at any time. A match copies one byte per cycle through the single read
// port of the ring RAM while the output register can take its words, and holds
// the input until it is done; words of up to OUT_LANES bytes leave as they fill.
// A full output register that is not taken stalls the parser and the copy.
module lzss_ring_decoder
  import lzss_pkg::*;
#(
  parameter int WINDOW_BITS = WINDOW_BITS_DEF,
  parameter int OUT_LANES   = OUT_LANES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,     // initial_position
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,       // in_byte
  input  wire logic        s_tlast,       // block_last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [79:0]      m_tdata,       // out_bytes[63:0], byte_count[67:64],
                                          // ring_position[79:68]
  output logic             m_tlast,       // run_last
  output logic             m_tuser        // block_done
);

  localparam int WB     = WINDOW_BITS;
  localparam int WORD_W = OUT_LANES * 8;
  localparam int LANE_W = $clog2(OUT_LANES);

  ctl_state_t state, state_next;
  phase_t     phase, phase_next;

  logic [8:0]        flag_bits, flag_next;
  logic [7:0]        offset_low, offset_low_next;
  logic [WB-1:0]     wpos, mpos, clr_addr;
  logic [LEN_W-1:0]  rem;
  logic              last_q;

  logic              rd_v, rd_final;
  logic [WB-1:0]     rd_addr_q;
  logic              wq_v;
  logic [WB-1:0]     wq_addr;
  logic [7:0]        wq_data;
  logic [7:0]        ram_q, fwd_byte;

  logic [WORD_W-1:0] pack, word_new;
  logic [LANE_W-1:0] lane;

  logic                 ov, ov_next;
  logic [WORD_W-1:0]    o_word;
  logic [CNT_W-1:0]     o_cnt;
  logic                 o_last, o_done;
  logic [POS_OUT_W-1:0] o_pos;

  logic accept, issue, clearing, start_copy, lit_emit, empty_emit, arr_emit, emit;
  logic [LEN_W-1:0] copy_len;
  logic [WB-1:0]    copy_pos;
  logic [8:0]       fb_src;
  logic [7:0]       fb_shift;
  logic             lane_full;
  logic             arr_lane_full;

  logic              we;
  logic [WB-1:0]     waddr;
  logic [7:0]        wdata;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      CTL_CLEAR: if (clr_addr == {WB{1'b1}}) state_next = CTL_PARSE;
      CTL_PARSE: if (accept && start_copy) state_next = CTL_COPY;
      CTL_COPY:  if (rd_v && rd_final) state_next = CTL_PARSE;
      default:   state_next = CTL_PARSE;
    endcase
  end

  // state outputs
  always_comb begin
    s_tready = 1'b0;
    clearing = 1'b0;
    issue    = 1'b0;
    unique case (state)
      CTL_CLEAR: clearing = 1'b1;
      CTL_PARSE: s_tready = !ov || m_tready;
      CTL_COPY:  issue = (rem != '0) &&
                         (!ov_next || ((rem != LEN_W'(1)) && !arr_lane_full));
      default:   s_tready = 1'b0;
    endcase
  end

  assign accept = s_tvalid && s_tready;

  // parser
  always_comb begin
    phase_next      = phase;
    flag_next       = flag_bits;
    offset_low_next = offset_low;
    start_copy      = 1'b0;
    lit_emit        = 1'b0;
    copy_len        = LEN_EXT_BASE + LEN_W'(s_tdata);
    copy_pos        = mpos;
    fb_src          = (phase == PH_FLAG) ? {1'b1, s_tdata} : flag_bits;
    fb_shift        = fb_src[8:1];
    case (phase)
      PH_LIT: begin
        lit_emit = 1'b1;
      end
      PH_LO: begin
        offset_low_next = s_tdata;
        phase_next      = PH_HI;
      end
      PH_HI: begin
        copy_pos = WB'({s_tdata[3:0], offset_low});
        copy_len = LEN_BASE + LEN_W'(s_tdata[7:4]);
        if (s_tdata[7:4] == LEN_CODE_EXT) begin
          phase_next = PH_EXTRA;
        end else begin
          start_copy = 1'b1;
        end
      end
      PH_EXTRA: begin
        start_copy = 1'b1;
      end
      default: begin
      end
    endcase
    if (phase == PH_FLAG || phase == PH_LIT || start_copy) begin
      flag_next = {1'b0, fb_shift};
      if (fb_shift == '0) begin
        phase_next = PH_FLAG;
      end else begin
        phase_next = fb_src[0] ? PH_LO : PH_LIT;
      end
    end
    if (s_tlast) begin
      phase_next = PH_FLAG;
      flag_next  = '0;
    end
  end

  assign empty_emit = s_tlast && !lit_emit && !start_copy;

  // ring RAM with forwarding of the previous cycle's write
  always_comb begin
    we    = 1'b0;
    waddr = wpos;
    wdata = fwd_byte;
    if (clearing) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (accept && lit_emit) begin
      we    = 1'b1;
      wdata = s_tdata;
    end else if (rd_v) begin
      we = 1'b1;
    end
  end

  lzss_ram #(.WIDTH(8), .DEPTH(1 << WB)) u_ring (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (mpos),
    .rdata (ram_q)
  );

  assign fwd_byte = (wq_v && wq_addr == rd_addr_q) ? wq_data : ram_q;

  // lane packing
  always_comb begin
    for (int i = 0; i < OUT_LANES; i++) begin
      word_new[i*8 +: 8] = (LANE_W'(i) == lane) ? fwd_byte : pack[i*8 +: 8];
    end
  end

  assign lane_full     = (lane == LANE_W'(OUT_LANES - 1));
  assign arr_lane_full = rd_v ? (lane == LANE_W'(OUT_LANES - 2)) : lane_full;
  assign arr_emit      = rd_v && (lane_full || rd_final);
  assign emit          = arr_emit || (accept && (lit_emit || empty_emit));
  assign ov_next       = emit || (ov && !m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= CTL_CLEAR;
      phase      <= PH_FLAG;
      flag_bits  <= '0;
      offset_low <= '0;
      wpos       <= '0;
      mpos       <= '0;
      rem        <= '0;
      clr_addr   <= '0;
      last_q     <= 1'b0;
      rd_v       <= 1'b0;
      rd_final   <= 1'b0;
      wq_v       <= 1'b0;
      lane       <= '0;
      pack       <= '0;
      ov         <= 1'b0;
    end else begin
      state    <= state_next;
      ov       <= ov_next;
      rd_v     <= issue;
      rd_final <= issue && (rem == LEN_W'(1));
      wq_v     <= we;
      if (clearing) begin
        clr_addr <= clr_addr + WB'(1);
      end
      if (accept) begin
        phase      <= phase_next;
        flag_bits  <= flag_next;
        offset_low <= offset_low_next;
        if (phase == PH_HI) begin
          mpos <= copy_pos;
        end
        if (start_copy) begin
          rem    <= copy_len;
          mpos   <= copy_pos;
          last_q <= s_tlast;
        end
      end
      if (issue) begin
        rem  <= rem - LEN_W'(1);
        mpos <= mpos + WB'(1);
      end
      if (rd_v) begin
        if (arr_emit) begin
          lane <= '0;
          pack <= '0;
        end else begin
          lane <= lane + LANE_W'(1);
          pack <= word_new;
        end
      end
      if (cfg_we) begin
        wpos <= WB'(cfg_wdata);
      end else if ((accept && lit_emit) || rd_v) begin
        wpos <= wpos + WB'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_q <= mpos;
    wq_addr   <= waddr;
    wq_data   <= wdata;
    if (emit) begin
      if (arr_emit) begin
        o_word <= word_new;
        o_cnt  <= CNT_W'(lane) + CNT_W'(1);
        o_last <= rd_final;
        o_done <= rd_final && last_q;
        o_pos  <= POS_OUT_W'(wpos + WB'(1));
      end else if (lit_emit) begin
        o_word <= WORD_W'(s_tdata);
        o_cnt  <= CNT_W'(1);
        o_last <= 1'b1;
        o_done <= s_tlast;
        o_pos  <= POS_OUT_W'(wpos + WB'(1));
      end else begin
        o_word <= '0;
        o_cnt  <= '0;
        o_last <= 1'b1;
        o_done <= 1'b1;
        o_pos  <= POS_OUT_W'(wpos);
      end
    end
  end

  assign m_tvalid = ov;
  assign m_tdata  = {o_pos, o_cnt, 64'(o_word)};
  assign m_tlast  = o_last;
  assign m_tuser  = o_done;

  a_arrival_in_copy: assert property (@(posedge clk) disable iff (rst)
    rd_v |-> state == CTL_COPY)
    else $error("ring read data arrived outside a copy");

  a_no_input_in_copy: assert property (@(posedge clk) disable iff (rst)
    state != CTL_PARSE |-> !s_tready)
    else $error("input ready outside parse state");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[67:64] <= CNT_W'(OUT_LANES))
    else $error("byte count exceeds lanes");

  a_rem_step: assert property (@(posedge clk) disable iff (rst)
    issue |=> rem == $past(rem) - LEN_W'(1))
    else $error("copy length did not advance");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    emit |-> !ov || m_tready)
    else $error("result overwrote a pending transfer");

endmodule
`default_nettype wire

FILE: sim/lzss_checker.sv
// Checker for the LZSS ring decoder: watches the config port and both streams,
// predicts the decoded words and compares each output transfer in order.
// Depends on lzss_pkg for the parse phase type.
`timescale 1ns / 1ps
`default_nettype none
module lzss_checker
  import lzss_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [11:0] cfg_wdata,
  input  wire logic        s_tvalid,
  input  wire logic        s_tready,
  input  wire logic [7:0]  s_tdata,
  input  wire logic        s_tlast,
  input  wire logic        m_tvalid,
  input  wire logic        m_tready,
  input  wire logic [79:0] m_tdata,
  input  wire logic        m_tlast,
  input  wire logic        m_tuser,
  output int               errors,
  output int               pending,
  output int               words_checked,
  output int               blocks_closed
);

  typedef struct packed {
    logic [63:0] data;
    logic [3:0]  count;
    logic [11:0] pos;
    logic        run_last;
    logic        done;
  } dec_word_t;

  logic [7:0]  ring [4096];
  logic [11:0] wr_pos;
  logic [8:0]  flag_sr;
  phase_t      phase;
  logic [7:0]  off_lo;
  logic [11:0] copy_pos;
  logic [8:0]  copy_len;
  dec_word_t   words_due [$];

  function automatic dec_word_t make_word(logic [63:0] d, logic [3:0] c);
    dec_word_t w;
    w = '0;
    w.data  = d;
    w.count = c;
    w.pos   = wr_pos;
    return w;
  endfunction

  function automatic void advance_token();
    logic bit0;
    bit0 = flag_sr[0];
    flag_sr = flag_sr >> 1;
    if (flag_sr == 0) phase = PH_FLAG;
    else phase = bit0 ? PH_LO : PH_LIT;
  endfunction

  function automatic void copy_match(ref dec_word_t made [$]);
    logic [63:0] acc;
    logic [3:0]  n;
    logic [7:0]  b;
    acc = '0;
    n = 0;
    for (int i = 0; i < copy_len; i++) begin
      b = ring[copy_pos];
      copy_pos = copy_pos + 1;
      ring[wr_pos] = b;
      wr_pos = wr_pos + 1;
      acc = acc | (64'(b) << (8 * n));
      n = n + 1;
      if (n == 8) begin
        made.push_back(make_word(acc, n));
        acc = '0;
        n = 0;
      end
    end
    if (n != 0) made.push_back(make_word(acc, n));
  endfunction

  function automatic void decode_byte(logic [7:0] b, logic last);
    dec_word_t made [$];
    logic [15:0] tok;
    case (phase)
      PH_LIT: begin
        ring[wr_pos] = b;
        wr_pos = wr_pos + 1;
        made.push_back(make_word(64'(b), 4'd1));
        advance_token();
      end
      PH_LO: begin
        off_lo = b;
        phase = PH_HI;
      end
      PH_HI: begin
        tok = {b, off_lo};
        copy_pos = tok[11:0];
        copy_len = 9'(tok[15:12]) + 9'd3;
        if (copy_len == 9'd18) phase = PH_EXTRA;
        else begin
          copy_match(made);
          advance_token();
        end
      end
      PH_EXTRA: begin
        copy_len = 9'd18 + 9'(b);
        copy_match(made);
        advance_token();
      end
      default: begin
        flag_sr = {1'b1, b};
        advance_token();
      end
    endcase
    if (last) begin
      if (made.size() == 0) made.push_back(make_word('0, '0));
      made[made.size()-1].done = 1'b1;
      phase = PH_FLAG;
      flag_sr = '0;
    end
    if (made.size() > 0) made[made.size()-1].run_last = 1'b1;
    foreach (made[i]) words_due.push_back(made[i]);
  endfunction

  always @(posedge clk) begin
    dec_word_t e;
    if (rst) begin
      foreach (ring[i]) ring[i] = '0;
      wr_pos = '0;
      flag_sr = '0;
      phase = PH_FLAG;
      off_lo = '0;
      copy_pos = '0;
      copy_len = '0;
      words_due.delete();
      errors = 0;
      words_checked = 0;
      blocks_closed = 0;
    end else begin
      if (cfg_we) wr_pos = cfg_wdata;
      if (s_tvalid && s_tready) decode_byte(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        if (words_due.size() == 0) begin
          $display("%0t: unexpected output transfer %h last=%b user=%b", $time,
                   m_tdata, m_tlast, m_tuser);
          errors++;
        end else begin
          e = words_due.pop_front();
          words_checked++;
          if (m_tuser) blocks_closed++;
          if (m_tdata[63:0] !== e.data) begin
            $display("%0t: out_bytes exp %h got %h", $time, e.data, m_tdata[63:0]);
            errors++;
          end
          if (m_tdata[67:64] !== e.count) begin
            $display("%0t: byte_count exp %0d got %0d", $time, e.count, m_tdata[67:64]);
            errors++;
          end
          if (m_tdata[79:68] !== e.pos) begin
            $display("%0t: ring_position exp %h got %h", $time, e.pos, m_tdata[79:68]);
            errors++;
          end
          if (m_tlast !== e.run_last) begin
            $display("%0t: run_last exp %b got %b", $time, e.run_last, m_tlast);
            errors++;
          end
          if (m_tuser !== e.done) begin
            $display("%0t: block_done exp %b got %b", $time, e.done, m_tuser);
            errors++;
          end
        end
      end
    end
    pending = words_due.size();
  end

endmodule
`default_nettype wire

FILE: sim/tb_top.sv
// Top of the LZSS ring decoder testbench: clock, reset, stimulus and verdict.
// Depends on lzss_pkg, lzss_ring_decoder and lzss_checker.
`timescale 1ns / 1ps
`default_nettype none
module tb_top
  import lzss_pkg::*;
;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic [11:0] cfg_wdata;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [79:0] m_tdata;
  logic        m_tlast;
  logic        m_tuser;
  int          errors;
  int          pending;
  int          words_checked;
  int          blocks_closed;
  int          gap_pct;
  int          stall_pct;
  int          bytes_sent;
  int          cycles = 0;

  lzss_ring_decoder dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser)
  );

  lzss_checker chk (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .m_tlast(m_tlast), .m_tuser(m_tuser), .errors(errors), .pending(pending),
    .words_checked(words_checked), .blocks_closed(blocks_closed)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(0, 99) >= stall_pct);
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb_top: FAIL");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    logic rdy;
    while ($urandom_range(0, 99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do begin
      @(negedge clk);
      rdy = s_tready;
      @(posedge clk);
    end while (!rdy);
    bytes_sent++;
  endtask

  task automatic load_position(input logic [11:0] p);
    s_tvalid  <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= p;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Length code: mostly short copies, some extended ones.
  function automatic logic [3:0] pick_len_code();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 4'($urandom_range(0, 3));
    if (r < 90) return 4'($urandom_range(4, 14));
    return LEN_CODE_EXT;
  endfunction

  // Well-formed block with random content; may end anywhere, mid-token too.
  task automatic random_block();
    logic [7:0] f;
    logic [7:0] lo;
    logic [3:0] lc;
    logic       stop;
    int         n_flags;
    n_flags = $urandom_range(1, 4);
    for (int k = 0; k < n_flags; k++) begin
      f = 8'($urandom);
      stop = ($urandom_range(0, 19) == 0);
      send_byte(f, stop);
      if (stop) return;
      for (int i = 0; i < 8; i++) begin
        stop = ($urandom_range(0, 29) == 0);
        if (!f[i]) begin
          send_byte(8'($urandom), stop);
          if (stop) return;
        end else begin
          lo = 8'($urandom);
          lc = pick_len_code();
          send_byte(lo, stop);
          if (stop) return;
          stop = ($urandom_range(0, 29) == 0);
          send_byte({lc, 4'($urandom)}, stop);
          if (stop) return;
          if (lc == LEN_CODE_EXT) begin
            stop = ($urandom_range(0, 29) == 0);
            send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15)),
                      stop);
            if (stop) return;
          end
        end
      end
    end
    send_byte(8'h00, 1'b1);
  endtask

  initial begin
    rst       <= 1'b1;
    cfg_we    <= 1'b0;
    cfg_wdata <= '0;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tlast   <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    bytes_sent = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    load_position(12'h000);

    // directed: empty block, overlap copy, extremes, drops mid-token
    send_byte(8'h00, 1'b1);
    send_byte(8'h02, 1'b0);
    send_byte(8'h41, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h70, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h0F, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hF0, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'hF2, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'h55, 1'b1);
    send_byte(8'h01, 1'b0);
    send_byte(8'h10, 1'b0);
    send_byte(8'hF0, 1'b1);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hE0, 1'b1);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: load_position(12'hFFF);
        1: load_position(12'($urandom));
        2: load_position(12'hFF8);
        default: load_position(12'h000);
      endcase
      gap_pct   = (ph == 1) ? 61 : (ph == 3) ? 16 : 0;
      stall_pct = (ph == 2) ? 61 : (ph == 3) ? 16 : 0;
      while (bytes_sent < 23 + 80 * (ph + 1)) begin
        if ($urandom_range(0, 9) == 0) send_byte(8'($urandom), 1'($urandom));
        else random_block();
      end
    end
    send_byte(8'h00, 1'b1);
    s_tvalid  <= 1'b0;
    gap_pct   = 0;
    stall_pct = 0;
    while (pending != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Sent %0d compressed bytes; checked %0d output words over %0d blocks.",
             bytes_sent, words_checked, blocks_closed);
    if (errors == 0 && pending == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: files.f
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_ram.sv
hw/rtl/lzss_ring_decoder.sv
sim/lzss_checker.sv
sim/tb_top.sv
